@@ design/ggnm_pkg.sv @@
// ----------------------------------------------------------------------------
// ggnm_pkg: shared types and constants for the gated nearest-match unit
// Coordinate, gate and distance widths, item mode codes and the control
// bundles that pass between the top level, the centroid cells and the
// distance pipeline.
// ----------------------------------------------------------------------------
package ggnm_pkg;

	localparam int COORD_W          = 16;          // signed Q5.10 metres
	localparam int GATE_W           = 15;          // unsigned Q5.10 metres
	localparam int MAG_W            = COORD_W;     // |a - b| of two COORD_W values
	localparam int SQ_W             = 2 * MAG_W;   // one squared difference
	localparam int D2_W             = SQ_W + 1;    // sum of two squares
	localparam int IDX_OUT_W        = 6;           // width of the reported match index
	localparam int MAX_CLUSTERS_DEF = 64;

	localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(205);  // 0.2 m

	localparam logic MODE_CLUSTER = 1'b0;
	localparam logic MODE_BEACON  = 1'b1;

	// per-cell control, decoded in the top level
	typedef struct packed {
		logic shift;     // take the neighbor's entry (ring rotation)
		logic load;      // write a new centroid into this cell
		logic clr_used;  // start of a new scan: drop the used mark
		logic mark;      // this cell won the last query
	} ggnm_cell_ctl_t;

	// beat tag that travels alongside the distance pipeline
	typedef struct packed {
		logic vld;       // a centroid is in this stage
		logic elig;      // stored and not yet used
	} ggnm_tag_t;

endpackage

@@ design/ggnm_cell.sv @@
// ----------------------------------------------------------------------------
// ggnm_cell: one centroid slot of the rotating centroid ring
// Holds one centroid and its used mark; during a scan it takes its
// neighbor's contents every cycle.
// ----------------------------------------------------------------------------
module ggnm_cell import ggnm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ggnm_cell_ctl_t            ctl,
	input  logic signed [COORD_W-1:0] wr_x,
	input  logic signed [COORD_W-1:0] wr_y,
	input  logic signed [COORD_W-1:0] nxt_x,
	input  logic signed [COORD_W-1:0] nxt_y,
	input  logic                      nxt_used,
	output logic signed [COORD_W-1:0] x,
	output logic signed [COORD_W-1:0] y,
	output logic                      used
);

	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic                      used_q;

	// centroid payload: no reset, never read before written
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			x_q <= nxt_x;
			y_q <= nxt_y;
		end else if (ctl.load) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.clr_used) begin
			used_q <= 1'b0;
		end else if (ctl.shift) begin
			used_q <= nxt_used;
		end else if (ctl.mark) begin
			used_q <= 1'b1;
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign used = used_q;

endmodule

@@ design/ggnm_dist.sv @@
// ----------------------------------------------------------------------------
// ggnm_dist: two-stage squared-distance pipeline
// s1 registers the absolute coordinate differences, s2 the two squares.
// The centroid, its index and its tag ride along.
// ----------------------------------------------------------------------------
module ggnm_dist import ggnm_pkg::*; #(
	parameter int IDX_W = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ggnm_tag_t                 tag,
	input  logic [IDX_W-1:0]          idx,
	input  logic signed [COORD_W-1:0] qx,
	input  logic signed [COORD_W-1:0] qy,
	input  logic signed [COORD_W-1:0] cx,
	input  logic signed [COORD_W-1:0] cy,
	output ggnm_tag_t                 tag_s2,
	output logic [IDX_W-1:0]          idx_s2,
	output logic signed [COORD_W-1:0] cx_s2,
	output logic signed [COORD_W-1:0] cy_s2,
	output logic [SQ_W-1:0]           sqx_s2,
	output logic [SQ_W-1:0]           sqy_s2
);

	logic signed [COORD_W:0]   dx;
	logic signed [COORD_W:0]   dy;
	logic [COORD_W:0]          mx;
	logic [COORD_W:0]          my;

	ggnm_tag_t                 tag_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic signed [COORD_W-1:0] cx_s1;
	logic signed [COORD_W-1:0] cy_s1;
	logic [MAG_W-1:0]          magx_s1;
	logic [MAG_W-1:0]          magy_s1;

	assign dx = (COORD_W+1)'(qx) - (COORD_W+1)'(cx);
	assign dy = (COORD_W+1)'(qy) - (COORD_W+1)'(cy);
	// magnitude of a difference of two 16-bit values fits 16 bits
	assign mx = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
	assign my = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		cx_s1   <= cx;
		cy_s1   <= cy;
		magx_s1 <= mx[MAG_W-1:0];
		magy_s1 <= my[MAG_W-1:0];

		idx_s2  <= idx_s1;
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		sqx_s2  <= SQ_W'(magx_s1) * SQ_W'(magx_s1);
		sqy_s2  <= SQ_W'(magy_s1) * SQ_W'(magy_s1);
	end

endmodule

@@ design/greedy_gated_nearest_match_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_gated_nearest_match_unit: greedy gated nearest-centroid matcher
// Stores cluster centroids in a ring of cells and matches beacon positions
// to the nearest unused centroid inside the gate.
// ----------------------------------------------------------------------------
// A cluster beat (mode 0) is taken and written into the next free
// cell; once MAX_CLUSTERS centroids are held, further clusters are dropped.
// A beacon beat (mode 1) rotates the whole ring of MAX_CLUSTERS cells once
// past a single squared-distance unit, one centroid per cycle, so a beacon
// occupies the block for a full pass of the ring and the pipeline drain,
// whatever the fill level. The nearest unused centroid with dist^2 <
// gate_distance^2 wins, the lowest index on a tie; it is marked used and
// one result beat is emitted (all zero when nothing matched). start_scan=1
// empties the store and clears every used mark before its beat is handled.
// A new input beat is taken while a result still waits at the output
// register. The user must write gate_distance through the cfg channel only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module greedy_gated_nearest_match_unit import ggnm_pkg::*; #(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [GATE_W-1:0]         gate_distance,

	// input beats
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic                      start_scan,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,

	// result beats
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      matched,
	output logic [IDX_OUT_W-1:0]      match_index,
	output logic signed [COORD_W-1:0] centroid_x,
	output logic signed [COORD_W-1:0] centroid_y
);

	localparam int IDX_W  = $clog2(MAX_CLUSTERS);
	localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int WIDE_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

	// controller states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                state_q;
	logic [IDX_W-1:0]          scan_cnt_q;
	logic [CNT_W-1:0]          count_q;
	logic [GATE_W-1:0]         gate_q;
	logic signed [COORD_W-1:0] qx_q;
	logic signed [COORD_W-1:0] qy_q;

	// running best of the current scan
	logic [D2_W-1:0]           best_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic signed [COORD_W-1:0] best_x_q;
	logic signed [COORD_W-1:0] best_y_q;
	logic                      found_q;

	// output register
	logic                      out_valid_q;
	logic                      matched_q;
	logic [IDX_OUT_W-1:0]      index_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;

	logic                      in_acc;
	logic                      scan_last;
	logic                      emit;
	logic [CNT_W-1:0]          count_eff;
	logic                      store_ok;
	logic [2*GATE_W-1:0]       gate_sq;
	logic [D2_W-1:0]           d2;
	logic                      better;
	logic [WIDE_W-1:0]         best_idx_wide;

	// ring of cells
	logic signed [COORD_W-1:0] cell_x [MAX_CLUSTERS];
	logic signed [COORD_W-1:0] cell_y [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0]   cell_used;

	// distance pipeline
	ggnm_tag_t                 head_tag;
	ggnm_tag_t                 tag_s2;
	logic [IDX_W-1:0]          idx_s2;
	logic signed [COORD_W-1:0] cx_s2;
	logic signed [COORD_W-1:0] cy_s2;
	logic [SQ_W-1:0]           sqx_s2;
	logic [SQ_W-1:0]           sqy_s2;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign scan_last = (scan_cnt_q == IDX_W'(MAX_CLUSTERS - 1));

	// store fill level as seen by this beat, after an optional clear
	assign count_eff = start_scan ? '0 : count_q;
	assign store_ok  = (count_eff < CNT_W'(MAX_CLUSTERS));

	// result leaves once the pipeline is empty and the output slot is free
	assign emit = (state_q == ST_DRAIN) && !tag_s2.vld && !head_tag.vld
		&& (!out_valid_q || out_ready);

	assign gate_sq = (2*GATE_W)'(gate_q) * (2*GATE_W)'(gate_q);

	// ---------------------------------------------------------------- cells
	// During a scan cell i takes cell i+1, so cell 0 (the head) presents
	// entry k in scan cycle k; after MAX_CLUSTERS shifts every entry is home.
	for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
		ggnm_cell_ctl_t ctl;

		assign ctl.shift    = (state_q == ST_SCAN);
		assign ctl.load     = in_acc && (mode == MODE_CLUSTER) && store_ok
			&& (count_eff == CNT_W'(i));
		assign ctl.clr_used = in_acc && start_scan;
		assign ctl.mark     = emit && found_q && (best_idx_q == IDX_W'(i));

		ggnm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_x     (pos_x),
			.wr_y     (pos_y),
			.nxt_x    (cell_x[(i + 1) % MAX_CLUSTERS]),
			.nxt_y    (cell_y[(i + 1) % MAX_CLUSTERS]),
			.nxt_used (cell_used[(i + 1) % MAX_CLUSTERS]),
			.x        (cell_x[i]),
			.y        (cell_y[i]),
			.used     (cell_used[i])
		);
	end

	// ---------------------------------------------------- distance pipeline
	// an entry takes part only if it is stored and not yet used
	assign head_tag.vld  = (state_q == ST_SCAN);
	assign head_tag.elig = ((CNT_W)'(scan_cnt_q) < count_q) && !cell_used[0];

	ggnm_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (head_tag),
		.idx    (scan_cnt_q),
		.qx     (qx_q),
		.qy     (qy_q),
		.cx     (cell_x[0]),
		.cy     (cell_y[0]),
		.tag_s2 (tag_s2),
		.idx_s2 (idx_s2),
		.cx_s2  (cx_s2),
		.cy_s2  (cy_s2),
		.sqx_s2 (sqx_s2),
		.sqy_s2 (sqy_s2)
	);

	// strict compare keeps the earliest index on a tie
	assign d2     = D2_W'(sqx_s2) + D2_W'(sqy_s2);
	assign better = tag_s2.vld && tag_s2.elig && (d2 < best_q);

	// ----------------------------------------------------------- controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
			count_q    <= '0;
			gate_q     <= GATE_RESET;
			found_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				gate_q <= gate_distance;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= count_eff + CNT_W'((mode == MODE_CLUSTER) && store_ok);
						if (mode == MODE_BEACON) begin
							scan_cnt_q <= '0;
							found_q    <= 1'b0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						scan_cnt_q <= '0;
						state_q    <= ST_DRAIN;
					end else begin
						scan_cnt_q <= scan_cnt_q + IDX_W'(1);
					end
					if (better) begin
						found_q <= 1'b1;
					end
				end
				ST_DRAIN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query position and running best: payload, no reset
	always_ff @(posedge clk) begin
		if (in_acc && (mode == MODE_BEACON)) begin
			qx_q   <= pos_x;
			qy_q   <= pos_y;
			best_q <= D2_W'(gate_sq);
		end else if (better) begin
			best_q     <= d2;
			best_idx_q <= idx_s2;
			best_x_q   <= cx_s2;
			best_y_q   <= cy_s2;
		end
	end

	// ------------------------------------------------------- output register
	assign best_idx_wide = WIDE_W'(best_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			matched_q <= found_q;
			index_q   <= found_q ? best_idx_wide[IDX_OUT_W-1:0] : '0;
			cx_q      <= found_q ? best_x_q : '0;
			cy_q      <= found_q ? best_y_q : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign matched     = matched_q;
	assign match_index = index_q;
	assign centroid_x  = cx_q;
	assign centroid_y  = cy_q;

`ifndef SYNTHESIS
	// the fill level never runs past the ring
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CLUSTERS))
		else $error("centroid count above capacity");

	// a winner is always a stored entry
	a_winner_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && found_q) |-> ((CNT_W)'(best_idx_q) < count_q))
		else $error("matched index beyond stored centroids");

	// no beat in the last stage of the distance pipeline while idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !tag_s2.vld)
		else $error("distance pipeline busy while idle");

	// a result without a match carries zero fields
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |-> (match_index == '0 && centroid_x == '0
			&& centroid_y == '0))
		else $error("unmatched result with nonzero fields");
`endif

endmodule
